/* hdl/cesd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// C escape sequence decoder package
// Request and result types, decoder modes and the character codes that the
// escape decoder recognizes.
// ----------------------------------------------------------------------------
package cesd_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_marker;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_done;
  } rsp_t;

  typedef enum logic [3:0] {
    ModeNormal = 4'b0001,
    ModeEscape = 4'b0010,
    ModeOct1   = 4'b0100,
    ModeOct2   = 4'b1000
  } mode_e;

  typedef struct packed {
    logic [1:0] count;
    rsp_t       first;
    rsp_t       second;
  } dec_t;

  localparam logic [7:0] CharBackslash = 8'h5C;
  localparam logic [7:0] CharZero      = 8'h30;
  localparam logic [7:0] CharSeven     = 8'h37;
  localparam logic [7:0] CharLowerB    = 8'h62;
  localparam logic [7:0] CharLowerF    = 8'h66;
  localparam logic [7:0] CharLowerN    = 8'h6E;
  localparam logic [7:0] CharLowerR    = 8'h72;
  localparam logic [7:0] CharLowerT    = 8'h74;
  localparam logic [7:0] CharLowerV    = 8'h76;
  localparam logic [7:0] CharQuote     = 8'h27;
  localparam logic [7:0] CharDquote    = 8'h22;
  localparam logic [7:0] CharQuestion  = 8'h3F;
  localparam logic [7:0] CharBackspace = 8'h08;
  localparam logic [7:0] CharFormFeed  = 8'h0C;
  localparam logic [7:0] CharNewline   = 8'h0A;
  localparam logic [7:0] CharReturn    = 8'h0D;
  localparam logic [7:0] CharTab       = 8'h09;
  localparam logic [7:0] CharVtab      = 8'h0B;
  localparam logic [7:0] CharNul       = 8'h00;

endpackage
`default_nettype wire

/* hdl/cesd_decode.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// C escape sequence decoder, decode step
// Combinational next-state and result logic for one request, given the
// current decoder mode and octal accumulator.
// ----------------------------------------------------------------------------
module cesd_decode import cesd_pkg::*; (
  input  mode_e      mode_i,
  input  logic [5:0] acc_i,
  input  req_t       req_i,
  output mode_e      mode_o,
  output logic [5:0] acc_o,
  output dec_t       dec_o
);

  logic [7:0] chr;
  logic       is_digit;
  logic [8:0] oct_val;
  logic       esc_hit;
  logic [7:0] esc_byte;
  rsp_t       term_rsp;
  rsp_t       acc_rsp;
  rsp_t       chr_rsp;

  assign chr      = req_i.in_byte;
  assign is_digit = chr inside {[CharZero:CharSeven]};
  assign oct_val  = {acc_i, chr[2:0]};
  assign term_rsp = '{out_byte: CharNul, run_last: 1'b1, string_done: 1'b1};
  assign acc_rsp  = '{out_byte: {2'b00, acc_i}, run_last: 1'b0, string_done: 1'b0};
  assign chr_rsp  = '{out_byte: chr, run_last: 1'b1, string_done: 1'b0};

  always_comb begin
    esc_hit  = 1'b1;
    esc_byte = chr;
    case (chr)
      CharLowerB:    esc_byte = CharBackspace;
      CharLowerF:    esc_byte = CharFormFeed;
      CharLowerN:    esc_byte = CharNewline;
      CharLowerR:    esc_byte = CharReturn;
      CharLowerT:    esc_byte = CharTab;
      CharLowerV:    esc_byte = CharVtab;
      CharBackslash: esc_byte = CharBackslash;
      CharQuote:     esc_byte = CharQuote;
      CharDquote:    esc_byte = CharDquote;
      CharQuestion:  esc_byte = CharQuestion;
      default:       esc_hit  = 1'b0;
    endcase
  end

  always_comb begin
    mode_o = mode_i;
    acc_o  = acc_i;
    dec_o  = '0;
    if (req_i.end_marker) begin
      mode_o = ModeNormal;
      acc_o  = '0;
      case (mode_i)
        ModeEscape: begin
          dec_o.count  = 2'd2;
          dec_o.first  = '{out_byte: CharBackslash, run_last: 1'b0, string_done: 1'b0};
          dec_o.second = term_rsp;
        end
        ModeOct1, ModeOct2: begin
          dec_o.count  = 2'd2;
          dec_o.first  = acc_rsp;
          dec_o.second = term_rsp;
        end
        default: begin
          dec_o.count = 2'd1;
          dec_o.first = term_rsp;
        end
      endcase
    end else begin
      case (mode_i)
        ModeNormal: begin
          if (chr == CharBackslash) begin
            mode_o = ModeEscape;
          end else begin
            dec_o.count = 2'd1;
            dec_o.first = chr_rsp;
          end
        end
        ModeEscape: begin
          if (is_digit) begin
            acc_o  = {3'b000, chr[2:0]};
            mode_o = ModeOct1;
          end else begin
            mode_o = ModeNormal;
            if (esc_hit) begin
              dec_o.count = 2'd1;
              dec_o.first = '{out_byte: esc_byte, run_last: 1'b1, string_done: 1'b0};
            end else begin
              dec_o.count  = 2'd2;
              dec_o.first  = '{out_byte: CharBackslash, run_last: 1'b0, string_done: 1'b0};
              dec_o.second = chr_rsp;
            end
          end
        end
        ModeOct1, ModeOct2: begin
          if (is_digit) begin
            if (mode_i == ModeOct1) begin
              acc_o  = oct_val[5:0];
              mode_o = ModeOct2;
            end else begin
              acc_o       = '0;
              mode_o      = ModeNormal;
              dec_o.count = 2'd1;
              dec_o.first = '{out_byte: oct_val[7:0], run_last: 1'b1, string_done: 1'b0};
            end
          end else begin
            acc_o = '0;
            if (chr == CharBackslash) begin
              mode_o      = ModeEscape;
              dec_o.count = 2'd1;
              dec_o.first = '{out_byte: {2'b00, acc_i}, run_last: 1'b1, string_done: 1'b0};
            end else begin
              mode_o       = ModeNormal;
              dec_o.count  = 2'd2;
              dec_o.first  = acc_rsp;
              dec_o.second = chr_rsp;
            end
          end
        end
        default: begin
          mode_o = ModeNormal;
          acc_o  = '0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* hdl/c_escape_sequence_decoder_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// C escape sequence decoder
// Expands backslash escapes in a byte stream, one character per cycle while the result queue has room.
//
//   Channel   Direction  Signals                          Payload
//   request   in         in_valid_i, in_stall_o, in_req_i req_t
//   result    out        out_valid_o, out_stall_i, out_rsp_o rsp_t
//
// A request is registered, then decoded from the input register, and its zero, one
// or two results enter a three-entry result queue. One request per cycle is
// sustained while each request gives at most one result and the output is
// not stalled; two-result requests are bounded by the single output port.
// Reset clears the decoder mode, the accumulator and the queue.
// The input register holds while the queue has fewer than two free entries.
// ----------------------------------------------------------------------------
module c_escape_sequence_decoder_top import cesd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o
);

  logic       in_vld_q;
  logic       in_vld_d;
  req_t       in_req_q;
  mode_e      mode_q;
  mode_e      mode_d;
  logic [5:0] acc_q;
  logic [5:0] acc_d;
  dec_t       dec;
  rsp_t       slot_q [3];
  rsp_t       slot_d [3];
  logic [1:0] cnt_q;
  logic [1:0] cnt_d;
  logic [1:0] cnt_pop;
  logic       advance;
  logic       in_accept;
  logic       pop;

  cesd_decode u_decode (
    .mode_i (mode_q),
    .acc_i  (acc_q),
    .req_i  (in_req_q),
    .mode_o (mode_d),
    .acc_o  (acc_d),
    .dec_o  (dec)
  );

  assign advance     = in_vld_q && (cnt_q <= 2'd1);
  assign in_stall_o  = in_vld_q && !advance;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign in_vld_d    = in_accept || (in_vld_q && !advance);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_rsp_o   = slot_q[0];
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    slot_d  = slot_q;
    cnt_pop = cnt_q;
    if (pop) begin
      slot_d[0] = slot_q[1];
      slot_d[1] = slot_q[2];
      cnt_pop   = cnt_q - 2'd1;
    end
    cnt_d = cnt_pop;
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        if ((dec.count != 2'd0) && (2'(i) == cnt_pop)) begin
          slot_d[i] = dec.first;
        end
        if ((dec.count == 2'd2) && (2'(i) == cnt_pop + 2'd1)) begin
          slot_d[i] = dec.second;
        end
      end
      cnt_d = cnt_pop + dec.count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      mode_q   <= ModeNormal;
      acc_q    <= '0;
      cnt_q    <= '0;
    end else begin
      in_vld_q <= in_vld_d;
      cnt_q    <= cnt_d;
      if (advance) begin
        mode_q <= mode_d;
        acc_q  <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_req_q <= in_req_i;
    end
    slot_q <= slot_d;
  end

endmodule
`default_nettype wire

/* hdl/cesd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// C escape sequence decoder checker
// Port-level properties of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module cesd_checker import cesd_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input req_t in_req_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input rsp_t out_rsp_o
);

  a_in_req_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_req_i))
    else $error("Request dropped or changed while stalled.");

  a_out_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Result valid dropped while stalled.");

  a_out_payload_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_rsp_o))
    else $error("Result changed while stalled.");

  a_done_is_last_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.string_done |->
      out_rsp_o.run_last && (out_rsp_o.out_byte == CharNul))
    else $error("Terminating result is not a final zero byte.");

  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_rsp_o.run_last |=> out_valid_o)
    else $error("Second result of a request is missing.");

endmodule

bind c_escape_sequence_decoder_top cesd_checker u_cesd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);
`default_nettype wire
